// ----- design/rpac_pkg.sv -----
`default_nettype none

package rpac_pkg;

    localparam int COORD_W   = 32;
    localparam int ANGLE_W   = 16;
    localparam int TRIG_W    = 32;
    localparam int FRAC_BITS = 29;
    localparam int MAX_STEPS = 32;

    localparam logic signed [TRIG_W-1:0] GAIN_Q29  = 32'sd326016437;
    localparam logic signed [TRIG_W-1:0] ROUND_Q29 = 32'sd268435456;

    // angle codes in binary turn units
    localparam logic signed [ANGLE_W:0] ANGLE_QUARTER = 17'sd16384;
    localparam logic signed [ANGLE_W:0] ANGLE_HALF    = 17'sd32768;

    // atan(2^-i), 2^32 units per turn
    localparam logic signed [TRIG_W-1:0] ATAN_TURNS [0:MAX_STEPS-1] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic        [ANGLE_W-1:0] turn_angle;
    } pt_beat_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] rotated_x;
        logic signed [COORD_W-1:0] rotated_y;
        logic                      overflow;
    } res_beat_t;

endpackage

`default_nettype wire

// ----- design/rotate_point_about_center_core.sv -----
`default_nettype none

// Rotates a Q16.16 point about a center by a binary angle (65536 per turn,
// counterclockwise) and saturates the result, flagging overflow. Fully
// pipelined: one beat per cycle sustained while the output is not stalled;
// it has one input stage, one stage per CORDIC iteration, then multiply, sum
// and saturate stages. Each stage holds under backpressure on its own, so beats
// keep entering until every stage is full.
module rotate_point_about_center_core #(
    parameter int ROTATION_STEPS = 16,
    parameter int COORD_BITS     = 32
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 pt_valid,
    output logic                      pt_ready,
    input  wire rpac_pkg::pt_beat_t   pt,
    output logic                      res_valid,
    input  wire logic                 res_ready,
    output rpac_pkg::res_beat_t       res
);

    localparam int STEPS = (ROTATION_STEPS < rpac_pkg::MAX_STEPS) ?
                           ROTATION_STEPS : rpac_pkg::MAX_STEPS;
    localparam int CW    = (COORD_BITS < rpac_pkg::COORD_W) ? COORD_BITS : rpac_pkg::COORD_W;
    localparam int DW    = CW + 1;
    localparam int TW    = rpac_pkg::TRIG_W;
    localparam int PW    = DW + TW + 1;
    localparam int RW    = PW - rpac_pkg::FRAC_BITS;
    localparam int SW    = RW + 1;
    localparam int NSTG  = STEPS + 4;
    localparam int S_MUL = STEPS + 1;
    localparam int S_SUM = STEPS + 2;

    localparam logic signed [SW-1:0] SAT_HI = SW'((longint'(1) <<< (CW - 1)) - 1);
    localparam logic signed [SW-1:0] SAT_LO = SW'(-(longint'(1) <<< (CW - 1)));

    // handshake chain
    logic [NSTG:0]   adv;
    logic [NSTG-1:0] v_reg;
    logic [NSTG-1:0] v_next;

    always_comb
    begin
        adv[NSTG] = res_ready;
        for (int n = NSTG - 1; n >= 0; n--)
        begin
            adv[n] = !v_reg[n] || adv[n+1];
        end
    end

    assign v_next = {v_reg[NSTG-2:0], pt_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int n = 0; n < NSTG; n++)
            begin
                if (adv[n])
                begin
                    v_reg[n] <= v_next[n];
                end
            end
        end
    end

    assign pt_ready  = adv[0];
    assign res_valid = v_reg[NSTG-1];

    // input stage: offsets and angle reduction
    localparam int ANGLE_W_L = rpac_pkg::ANGLE_W;

    logic signed [CW-1:0]      px_in;
    logic signed [CW-1:0]      py_in;
    logic signed [CW-1:0]      cx_in;
    logic signed [CW-1:0]      cy_in;
    logic signed [ANGLE_W_L:0] ang;
    logic signed [ANGLE_W_L:0] ang_red;
    logic                      flip;
    logic signed [DW-1:0]      dx0_next;
    logic signed [DW-1:0]      dy0_next;
    logic signed [TW-1:0]      z0_next;

    always_comb
    begin
        px_in   = pt.point_x[CW-1:0];
        py_in   = pt.point_y[CW-1:0];
        cx_in   = pt.center_x[CW-1:0];
        cy_in   = pt.center_y[CW-1:0];
        ang     = (ANGLE_W_L + 1)'($signed(pt.turn_angle));
        flip    = 1'b0;
        ang_red = ang;
        if (ang > rpac_pkg::ANGLE_QUARTER)
        begin
            ang_red = ang - rpac_pkg::ANGLE_HALF;
            flip    = 1'b1;
        end
        else if (ang < -rpac_pkg::ANGLE_QUARTER)
        begin
            ang_red = ang + rpac_pkg::ANGLE_HALF;
            flip    = 1'b1;
        end
        // a half-turn flip negates cos and sin; fold it into the offsets
        if (flip)
        begin
            dx0_next = DW'(cx_in) - DW'(px_in);
            dy0_next = DW'(cy_in) - DW'(py_in);
        end
        else
        begin
            dx0_next = DW'(px_in) - DW'(cx_in);
            dy0_next = DW'(py_in) - DW'(cy_in);
        end
        z0_next = TW'(ang_red) <<< 16;
    end

    // stage payload
    logic signed [DW-1:0] dx_reg [0:STEPS];
    logic signed [DW-1:0] dy_reg [0:STEPS];
    logic signed [CW-1:0] cx_reg [0:S_SUM];
    logic signed [CW-1:0] cy_reg [0:S_SUM];
    logic signed [TW-1:0] z_reg  [0:STEPS-1];
    logic signed [TW-1:0] x_reg  [1:STEPS];
    logic signed [TW-1:0] y_reg  [1:STEPS];
    logic signed [TW-1:0] x_next [1:STEPS];
    logic signed [TW-1:0] y_next [1:STEPS];
    logic signed [TW-1:0] z_next [1:STEPS-1];

    genvar j;
    generate
        for (j = 1; j <= STEPS; j++)
        begin : g_step
            logic signed [TW-1:0] x_in;
            logic signed [TW-1:0] y_in;
            logic signed [TW-1:0] x_sh;
            logic signed [TW-1:0] y_sh;
            logic                 pos;

            if (j == 1)
            begin : g_first
                assign x_in = rpac_pkg::GAIN_Q29;
                assign y_in = '0;
            end
            else
            begin : g_mid
                assign x_in = x_reg[j-1];
                assign y_in = y_reg[j-1];
            end

            assign pos  = !z_reg[j-1][TW-1];
            assign x_sh = x_in >>> (j - 1);
            assign y_sh = y_in >>> (j - 1);
            assign x_next[j] = pos ? (x_in - y_sh) : (x_in + y_sh);
            assign y_next[j] = pos ? (y_in + x_sh) : (y_in - x_sh);

            if (j < STEPS)
            begin : g_z
                assign z_next[j] = pos ? (z_reg[j-1] - rpac_pkg::ATAN_TURNS[j-1]) :
                                         (z_reg[j-1] + rpac_pkg::ATAN_TURNS[j-1]);
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            dx_reg[0] <= dx0_next;
            dy_reg[0] <= dy0_next;
            cx_reg[0] <= cx_in;
            cy_reg[0] <= cy_in;
            z_reg[0]  <= z0_next;
        end
        for (int k = 1; k <= STEPS; k++)
        begin
            if (adv[k])
            begin
                x_reg[k]  <= x_next[k];
                y_reg[k]  <= y_next[k];
                dx_reg[k] <= dx_reg[k-1];
                dy_reg[k] <= dy_reg[k-1];
                cx_reg[k] <= cx_reg[k-1];
                cy_reg[k] <= cy_reg[k-1];
            end
        end
        for (int k = 1; k < STEPS; k++)
        begin
            if (adv[k])
            begin
                z_reg[k] <= z_next[k];
            end
        end
        for (int k = S_MUL; k <= S_SUM; k++)
        begin
            if (adv[k])
            begin
                cx_reg[k] <= cx_reg[k-1];
                cy_reg[k] <= cy_reg[k-1];
            end
        end
    end

    // multiply stage
    logic signed [PW-1:0] pxc_reg;
    logic signed [PW-1:0] pys_reg;
    logic signed [PW-1:0] pxs_reg;
    logic signed [PW-1:0] pyc_reg;

    always_ff @(posedge clk)
    begin
        if (adv[S_MUL])
        begin
            pxc_reg <= PW'(dx_reg[STEPS]) * PW'(x_reg[STEPS]);
            pys_reg <= PW'(dy_reg[STEPS]) * PW'(y_reg[STEPS]);
            pxs_reg <= PW'(dx_reg[STEPS]) * PW'(y_reg[STEPS]);
            pyc_reg <= PW'(dy_reg[STEPS]) * PW'(x_reg[STEPS]);
        end
    end

    // sum, round and rescale
    logic signed [PW-1:0] sx;
    logic signed [PW-1:0] sy;
    logic signed [RW-1:0] rx_reg;
    logic signed [RW-1:0] ry_reg;

    assign sx = pxc_reg - pys_reg + PW'(rpac_pkg::ROUND_Q29);
    assign sy = pxs_reg + pyc_reg + PW'(rpac_pkg::ROUND_Q29);

    always_ff @(posedge clk)
    begin
        if (adv[S_SUM])
        begin
            rx_reg <= RW'(sx >>> rpac_pkg::FRAC_BITS);
            ry_reg <= RW'(sy >>> rpac_pkg::FRAC_BITS);
        end
    end

    // recenter and saturate
    logic signed [SW-1:0] tx;
    logic signed [SW-1:0] ty;
    logic signed [CW-1:0] satx;
    logic signed [CW-1:0] saty;
    logic                 ovx;
    logic                 ovy;
    rpac_pkg::res_beat_t  res_next;
    rpac_pkg::res_beat_t  res_reg;

    always_comb
    begin
        tx = SW'(rx_reg) + SW'(cx_reg[S_SUM]);
        ty = SW'(ry_reg) + SW'(cy_reg[S_SUM]);
        ovx = 1'b1;
        ovy = 1'b1;
        if (tx > SAT_HI)
        begin
            satx = CW'(SAT_HI);
        end
        else if (tx < SAT_LO)
        begin
            satx = CW'(SAT_LO);
        end
        else
        begin
            satx = CW'(tx);
            ovx  = 1'b0;
        end
        if (ty > SAT_HI)
        begin
            saty = CW'(SAT_HI);
        end
        else if (ty < SAT_LO)
        begin
            saty = CW'(SAT_LO);
        end
        else
        begin
            saty = CW'(ty);
            ovy  = 1'b0;
        end
        res_next.rotated_x = rpac_pkg::COORD_W'(satx);
        res_next.rotated_y = rpac_pkg::COORD_W'(saty);
        res_next.overflow  = ovx || ovy;
    end

    always_ff @(posedge clk)
    begin
        if (adv[NSTG-1])
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

`default_nettype wire

// ----- design/rpac_checker.sv -----
`default_nettype none

module rpac_checker #(
    parameter int COORD_BITS = 32
) (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                pt_valid,
    input wire logic                pt_ready,
    input wire rpac_pkg::pt_beat_t  pt,
    input wire logic                res_valid,
    input wire logic                res_ready,
    input wire rpac_pkg::res_beat_t res
);

    localparam int CW = (COORD_BITS < rpac_pkg::COORD_W) ? COORD_BITS : rpac_pkg::COORD_W;
    localparam logic signed [rpac_pkg::COORD_W-1:0] HI =
        rpac_pkg::COORD_W'((longint'(1) <<< (CW - 1)) - 1);
    localparam logic signed [rpac_pkg::COORD_W-1:0] LO =
        rpac_pkg::COORD_W'(-(longint'(1) <<< (CW - 1)));

    // result beat holds while stalled
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("result beat changed under backpressure");

    // input is only held off when every stage is full and output is blocked
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !pt_ready |-> res_valid && !res_ready)
        else $error("input stalled while pipeline has room");

    // overflow implies a coordinate sits on a bound
    a_ovf_bound: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.overflow |->
            res.rotated_x == HI || res.rotated_x == LO ||
            res.rotated_y == HI || res.rotated_y == LO)
        else $error("overflow flagged without saturated coordinate");

    // input beat holds while stalled
    a_pt_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pt_valid && !pt_ready |=> pt_valid && $stable(pt))
        else $error("input beat changed under backpressure");

    // pipeline comes out of reset empty
    a_reset_empty: assert property (@(posedge clk)
        rst_n && !$past(rst_n) |-> !res_valid)
        else $error("result valid right after reset");

endmodule

bind rotate_point_about_center_core rpac_checker #(
    .COORD_BITS(COORD_BITS)
) u_rpac_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .pt_valid  (pt_valid),
    .pt_ready  (pt_ready),
    .pt        (pt),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
);

`default_nettype wire

// ----- bench/rotate_point_about_center_core_tb.sv -----
module rotate_point_about_center_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STEPS      = 16;
    localparam int CBITS      = 32;
    localparam int LATENCY    = STEPS + 4;
    localparam int N_RANDOM   = 1400;
    localparam int IDLE_LIMIT = 3000;
    localparam int DRAIN_A    = 120;
    localparam int DRAIN_B    = 900;
    localparam int HOLD_AT    = 400;
    localparam int HOLD_LEN   = 300;

    localparam longint GAIN      = 64'sd326016437;
    localparam longint ROUND_ADD = 64'sd268435456;
    localparam longint COORD_MAX = 64'sd2147483647;
    localparam longint COORD_MIN = -64'sd2147483648;

    localparam longint ATAN_TAB [0:31] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
        64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
        64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
        64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051,
        64'h00000029, 64'h00000014, 64'h0000000A, 64'h00000005,
        64'h00000003, 64'h00000001, 64'h00000001, 64'h00000000
    };

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                pt_valid  = 1'b0;
    logic                pt_ready;
    rpac_pkg::pt_beat_t  pt        = '0;
    logic                res_valid;
    logic                res_ready = 1'b0;
    rpac_pkg::res_beat_t res;

    rpac_pkg::pt_beat_t  point_q [$];
    rpac_pkg::res_beat_t expected_rot_q [$];
    int                  err_cnt  = 0;
    int                  idle_cyc = 0;

    rotate_point_about_center_core #(
        .ROTATION_STEPS(STEPS),
        .COORD_BITS    (CBITS)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .pt_valid (pt_valid),
        .pt_ready (pt_ready),
        .pt       (pt),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res      (res)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic signed [31:0] sat_coord(input longint v, inout logic ovf);
        if (v > COORD_MAX)
        begin
            ovf = 1'b1;
            return COORD_MAX[31:0];
        end
        if (v < COORD_MIN)
        begin
            ovf = 1'b1;
            return COORD_MIN[31:0];
        end
        return v[31:0];
    endfunction

    function automatic rpac_pkg::res_beat_t rotate_about_center_expect(rpac_pkg::pt_beat_t b);
        longint              ang, x, y, z, nx, cs, sn;
        longint              px, py, cx, cy, dx, dy, rx, ry;
        logic                flip;
        logic                ovf;
        rpac_pkg::res_beat_t r;
        px   = longint'(b.point_x);
        py   = longint'(b.point_y);
        cx   = longint'(b.center_x);
        cy   = longint'(b.center_y);
        dx   = px - cx;
        dy   = py - cy;
        ang  = longint'(b.turn_angle);
        flip = 1'b0;
        if (ang >= 32768)
            ang -= 65536;
        if (ang > 16384)
        begin
            ang -= 32768;
            flip = 1'b1;
        end
        else if (ang < -16384)
        begin
            ang += 32768;
            flip = 1'b1;
        end
        x = GAIN;
        y = 0;
        z = ang * 65536;
        for (int i = 0; i < ((STEPS < 32) ? STEPS : 32); i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - ATAN_TAB[i];
            end
            else
            begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + ATAN_TAB[i];
            end
            x = nx;
        end
        cs = flip ? -x : x;
        sn = flip ? -y : y;
        rx = (dx * cs - dy * sn + ROUND_ADD) >>> 29;
        ry = (dx * sn + dy * cs + ROUND_ADD) >>> 29;
        ovf = 1'b0;
        r.rotated_x = sat_coord(rx + cx, ovf);
        r.rotated_y = sat_coord(ry + cy, ovf);
        r.overflow  = ovf;
        return r;
    endfunction

    function automatic rpac_pkg::pt_beat_t mk_point(logic [31:0] px, logic [31:0] py,
                                                    logic [31:0] cx, logic [31:0] cy,
                                                    logic [15:0] ang);
        rpac_pkg::pt_beat_t b;
        b.point_x    = px;
        b.point_y    = py;
        b.center_x   = cx;
        b.center_y   = cy;
        b.turn_angle = ang;
        return b;
    endfunction

    function automatic logic [31:0] corner_coord();
        case ($urandom_range(0, 6))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            4: return 32'h0000_0001;
            5: return 32'h0001_0000;
            default: return 32'hFFFF_0000;
        endcase
    endfunction

    function automatic logic [15:0] corner_angle();
        case ($urandom_range(0, 10))
            0: return 16'd0;
            1: return 16'd16383;
            2: return 16'd16384;
            3: return 16'd16385;
            4: return 16'd32767;
            5: return 16'd32768;
            6: return 16'd32769;
            7: return 16'd49151;
            8: return 16'd49152;
            9: return 16'd49153;
            default: return 16'd65535;
        endcase
    endfunction

    // sender: bursts and gaps, two drain pauses
    int burst_left = 0;
    int gap_left   = 0;
    int popped     = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pt_valid <= 1'b0;
            pt       <= '0;
        end
        else
        begin
            if (pt_valid && pt_ready)
                expected_rot_q.push_back(rotate_about_center_expect(pt));
            if (!pt_valid || pt_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    pt_valid <= 1'b0;
                end
                else if (point_q.size() == 0 ||
                         ((popped == DRAIN_A || popped == DRAIN_B) &&
                          expected_rot_q.size() != 0))
                begin
                    pt_valid <= 1'b0;
                end
                else
                begin
                    pt       <= point_q.pop_front();
                    pt_valid <= 1'b1;
                    popped++;
                    if (burst_left > 0)
                        burst_left--;
                    if (burst_left == 0)
                    begin
                        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                                : $urandom_range(1, 30);
                        gap_left   = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 12);
                    end
                end
            end
        end
    end

    // receiver: own stall pattern plus one long hold
    int                  rcv_cnt    = 0;
    int                  hold_left  = 0;
    logic                long_done  = 1'b0;
    int                  ready_mode = 0;
    int                  mode_left  = 0;
    int                  cyc_cnt    = 0;
    rpac_pkg::res_beat_t want;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ready <= 1'b0;
        end
        else
        begin
            cyc_cnt++;
            if (res_valid && res_ready)
            begin
                if (expected_rot_q.size() == 0)
                begin
                    $error("unexpected beat: rotated_x=%0d rotated_y=%0d overflow=%0b",
                           res.rotated_x, res.rotated_y, res.overflow);
                    err_cnt++;
                end
                else
                begin
                    want = expected_rot_q.pop_front();
                    if (res.rotated_x !== want.rotated_x)
                    begin
                        $error("rotated_x: expected %0d, actual %0d",
                               want.rotated_x, res.rotated_x);
                        err_cnt++;
                    end
                    if (res.rotated_y !== want.rotated_y)
                    begin
                        $error("rotated_y: expected %0d, actual %0d",
                               want.rotated_y, res.rotated_y);
                        err_cnt++;
                    end
                    if (res.overflow !== want.overflow)
                    begin
                        $error("overflow: expected %0b, actual %0b",
                               want.overflow, res.overflow);
                        err_cnt++;
                    end
                end
                rcv_cnt++;
            end
            if (!long_done && rcv_cnt >= HOLD_AT)
            begin
                long_done = 1'b1;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    ready_mode = $urandom_range(0, 3);
                    mode_left  = $urandom_range(20, 150);
                end
                else
                begin
                    mode_left--;
                end
                case (ready_mode)
                    0: res_ready <= 1'b1;
                    1: res_ready <= 1'($urandom_range(0, 1));
                    2: res_ready <= ($urandom_range(0, 3) == 0);
                    default: res_ready <= (cyc_cnt % 5 != 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (pt_valid && pt_ready) || (res_valid && res_ready))
            idle_cyc <= 0;
        else
            idle_cyc <= idle_cyc + 1;
    end

    initial
    begin
        wait (idle_cyc >= IDLE_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        logic [31:0] cx, cy;
        logic [15:0] ang;
        int          kind;

        point_q.push_back(mk_point(32'h0, 32'h0, 32'h0, 32'h0, 16'd0));
        point_q.push_back(mk_point(32'h0001_0000, 32'h0, 32'h0, 32'h0, 16'd16384));
        point_q.push_back(mk_point(32'h0001_0000, 32'h0002_0000, 32'h0, 32'h0, 16'd32768));
        point_q.push_back(mk_point(32'h0001_0000, 32'h0002_0000, 32'h0, 32'h0, 16'd49152));
        point_q.push_back(mk_point(32'h0003_0000, 32'hFFFE_0000, 32'h0, 32'h0, 16'd16385));
        point_q.push_back(mk_point(32'h0003_0000, 32'hFFFE_0000, 32'h0, 32'h0, 16'hBFFF));
        point_q.push_back(mk_point(32'h0100_0000, 32'h0, 32'h0, 32'h0, 16'hFFFF));
        point_q.push_back(mk_point(32'h0100_0000, 32'h0, 32'h0, 32'h0, 16'd1));
        point_q.push_back(mk_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                                   16'd0));
        point_q.push_back(mk_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                                   16'd32768));
        point_q.push_back(mk_point(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                   16'd32768));
        point_q.push_back(mk_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h0, 16'd8192));
        point_q.push_back(mk_point(32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0, 16'd8192));
        point_q.push_back(mk_point(32'h1234_5678, 32'hEDCB_A987, 32'h1234_5678, 32'hEDCB_A987,
                                   16'd12345));
        point_q.push_back(mk_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                   16'd20000));
        point_q.push_back(mk_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                                   16'd24576));
        point_q.push_back(mk_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0, 16'd40000));
        point_q.push_back(mk_point(32'h0001_0000, 32'h0, 32'h7FFF_0000, 32'h0, 16'd16384));
        point_q.push_back(mk_point(32'h0005_0000, 32'h0007_0000, 32'h0001_0000, 32'h0, 16'h8001));
        point_q.push_back(mk_point(32'h0005_0000, 32'h0007_0000, 32'h0001_0000, 32'h0, 16'h7FFF));
        point_q.push_back(mk_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h5555_5555, 32'h5555_5555,
                                   16'hAAAA));
        point_q.push_back(mk_point(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                                   16'h5555));

        for (int n = 0; n < N_RANDOM; n++)
        begin
            kind = $urandom_range(0, 9);
            ang  = ($urandom_range(0, 4) == 0) ? corner_angle() : 16'($urandom);
            case (kind)
                0, 1, 2, 3:
                    point_q.push_back(mk_point($urandom, $urandom, $urandom, $urandom, ang));
                4, 5, 6:
                begin
                    cx = $urandom;
                    cy = $urandom;
                    point_q.push_back(mk_point(cx + 32'($signed($urandom_range(0, 2097152)) - 1048576),
                                               cy + 32'($signed($urandom_range(0, 2097152)) - 1048576),
                                               cx, cy, ang));
                end
                7:
                    point_q.push_back(mk_point(32'($signed($urandom_range(0, 524288)) - 262144),
                                               32'($signed($urandom_range(0, 524288)) - 262144),
                                               32'($signed($urandom_range(0, 524288)) - 262144),
                                               32'($signed($urandom_range(0, 524288)) - 262144),
                                               ang));
                default:
                    point_q.push_back(mk_point(corner_coord(), corner_coord(),
                                               corner_coord(), corner_coord(), ang));
            endcase
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (point_q.size() != 0 || pt_valid)
            @(posedge clk);
        while (expected_rot_q.size() != 0)
            @(posedge clk);
        repeat (2 * LATENCY) @(posedge clk);

        if (expected_rot_q.size() != 0)
        begin
            $error("%0d expected beats never arrived", expected_rot_q.size());
            err_cnt++;
        end
        if (err_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/rpac_pkg.sv
design/rotate_point_about_center_core.sv
design/rpac_checker.sv
bench/rotate_point_about_center_core_tb.sv
